// ===== hdl/wbrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wbrp_pkg
// Shared types and constants for the write batch record parser.
// ----------------------------------------------------------------------------
package wbrp_pkg;

   localparam int HeaderBytes = 12;
   localparam int SeqBytes    = 8;
   localparam int VarintMax   = 5;

   localparam int RspDataWidth = 80;
   localparam int RspUserWidth = 3;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TAG,
      PH_KEYLEN,
      PH_KEY,
      PH_VALLEN,
      PH_VAL,
      PH_ERROR
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_HEADER,
      ROLE_TAG,
      ROLE_KEYLEN,
      ROLE_KEY,
      ROLE_VALLEN,
      ROLE_VAL,
      ROLE_IGNORED
   } role_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_BADPUT,
      ST_BADDEL,
      ST_BADTAG,
      ST_COUNT
   } status_type;

   localparam logic [7:0] TagDelete = 8'h00;
   localparam logic [7:0] TagPut    = 8'h01;

   typedef struct packed {
      role_type    role;
      logic [7:0]  data;
      logic        rec_end;
      logic        rec_put;
      logic [63:0] rec_seq;
      logic        stat_valid;
      status_type  stat_code;
   } result_type;

endpackage

// ===== hdl/wbrp_parser.sv =====
// ----------------------------------------------------------------------------
// wbrp_parser
// Parser state and per-byte decode; state advances on each accepted beat.
// ----------------------------------------------------------------------------
module wbrp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           byte_in,
   input  logic                 last_byte,
   output wbrp_pkg::result_type result
);
   import wbrp_pkg::*;

   phase_type   phase_ff, phase_in, phase_nx;
   logic [3:0]  hdr_idx_ff, hdr_idx_in, hdr_idx_nx;
   logic [63:0] next_seq_ff, next_seq_in, next_seq_nx;
   logic [31:0] exp_count_ff, exp_count_in, exp_count_nx;
   logic [31:0] accum_ff, accum_in, accum_nx;
   logic [2:0]  vbytes_ff, vbytes_in, vbytes_nx;
   logic [31:0] left_ff, left_in, left_nx;
   logic        is_put_ff, is_put_in, is_put_nx;
   logic [31:0] found_ff, found_in, found_nx;
   status_type  err_ff, err_in, err_nx;

   logic        finish;
   logic [5:0]  vshift;
   logic [31:0] accum_or;
   logic [31:0] left_dec;

   assign vshift   = {vbytes_ff, 3'b000} - {3'b000, vbytes_ff};
   assign accum_or = accum_ff | (32'(byte_in[6:0]) << vshift);
   assign left_dec = left_ff - 32'd1;

   // next state
   always_comb begin
      phase_nx     = phase_ff;
      hdr_idx_nx   = hdr_idx_ff;
      next_seq_nx  = next_seq_ff;
      exp_count_nx = exp_count_ff;
      accum_nx     = accum_ff;
      vbytes_nx    = vbytes_ff;
      left_nx      = left_ff;
      is_put_nx    = is_put_ff;
      found_nx     = found_ff;
      err_nx       = err_ff;
      finish       = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_idx_ff < 4'(SeqBytes)) begin
               next_seq_nx = next_seq_ff | (64'(byte_in) << {hdr_idx_ff[2:0], 3'b000});
            end else if (hdr_idx_ff < 4'(HeaderBytes)) begin
               exp_count_nx = exp_count_ff | (32'(byte_in) << {hdr_idx_ff[1:0], 3'b000});
            end
            hdr_idx_nx = hdr_idx_ff + 4'd1;
            if (hdr_idx_nx >= 4'(HeaderBytes)) begin
               phase_nx = PH_TAG;
            end
         end
         PH_TAG: begin
            accum_nx  = '0;
            vbytes_nx = '0;
            if (byte_in == TagPut) begin
               is_put_nx = 1'b1;
               phase_nx  = PH_KEYLEN;
            end else if (byte_in == TagDelete) begin
               is_put_nx = 1'b0;
               phase_nx  = PH_KEYLEN;
            end else begin
               err_nx   = ST_BADTAG;
               phase_nx = PH_ERROR;
            end
         end
         PH_KEYLEN, PH_VALLEN: begin
            if (vbytes_ff < 3'(VarintMax)) begin
               accum_nx = accum_or;
            end
            vbytes_nx = vbytes_ff + 3'd1;
            if (byte_in[7]) begin
               if (vbytes_nx >= 3'(VarintMax)) begin
                  err_nx   = is_put_ff ? ST_BADPUT : ST_BADDEL;
                  phase_nx = PH_ERROR;
               end
            end else begin
               accum_nx  = '0;
               vbytes_nx = '0;
               if (accum_or == 32'd0) begin
                  if (phase_ff == PH_KEYLEN && is_put_ff) begin
                     phase_nx = PH_VALLEN;
                  end else begin
                     finish = 1'b1;
                  end
               end else begin
                  left_nx  = accum_or;
                  phase_nx = (phase_ff == PH_KEYLEN) ? PH_KEY : PH_VAL;
               end
            end
         end
         PH_KEY, PH_VAL: begin
            left_nx = left_dec;
            if (left_dec == 32'd0) begin
               if (phase_ff == PH_KEY && is_put_ff) begin
                  accum_nx  = '0;
                  vbytes_nx = '0;
                  phase_nx  = PH_VALLEN;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (finish) begin
         next_seq_nx = next_seq_ff + 64'd1;
         found_nx    = found_ff + 32'd1;
         phase_nx    = PH_TAG;
      end
   end

   // end of batch returns everything to the header state
   always_comb begin
      if (last_byte) begin
         phase_in     = PH_HEADER;
         hdr_idx_in   = '0;
         next_seq_in  = '0;
         exp_count_in = '0;
         accum_in     = '0;
         vbytes_in    = '0;
         left_in      = '0;
         is_put_in    = 1'b0;
         found_in     = '0;
         err_in       = ST_OK;
      end else begin
         phase_in     = phase_nx;
         hdr_idx_in   = hdr_idx_nx;
         next_seq_in  = next_seq_nx;
         exp_count_in = exp_count_nx;
         accum_in     = accum_nx;
         vbytes_in    = vbytes_nx;
         left_in      = left_nx;
         is_put_in    = is_put_nx;
         found_in     = found_nx;
         err_in       = err_nx;
      end
   end

   // outputs
   always_comb begin
      result.data       = byte_in;
      result.rec_end    = finish;
      result.rec_put    = finish & is_put_ff;
      result.rec_seq    = finish ? next_seq_ff : 64'd0;
      result.stat_valid = last_byte;
      unique case (phase_ff)
         PH_HEADER: result.role = ROLE_HEADER;
         PH_TAG:    result.role = ROLE_TAG;
         PH_KEYLEN: result.role = ROLE_KEYLEN;
         PH_KEY:    result.role = ROLE_KEY;
         PH_VALLEN: result.role = ROLE_VALLEN;
         PH_VAL:    result.role = ROLE_VAL;
         default:   result.role = ROLE_IGNORED;
      endcase
      if (!last_byte) begin
         result.stat_code = ST_OK;
      end else begin
         unique case (phase_nx)
            PH_ERROR:  result.stat_code = err_nx;
            PH_HEADER: result.stat_code = ST_SHORT;
            PH_TAG:    result.stat_code = (found_nx == exp_count_nx) ? ST_OK : ST_COUNT;
            default:   result.stat_code = is_put_nx ? ST_BADPUT : ST_BADDEL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_idx_ff   <= '0;
         next_seq_ff  <= '0;
         exp_count_ff <= '0;
         accum_ff     <= '0;
         vbytes_ff    <= '0;
         left_ff      <= '0;
         is_put_ff    <= 1'b0;
         found_ff     <= '0;
         err_ff       <= ST_OK;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         next_seq_ff  <= next_seq_in;
         exp_count_ff <= exp_count_in;
         accum_ff     <= accum_in;
         vbytes_ff    <= vbytes_in;
         left_ff      <= left_in;
         is_put_ff    <= is_put_in;
         found_ff     <= found_in;
         err_ff       <= err_in;
      end
   end

endmodule

// ===== hdl/write_batch_record_parser_unit.sv =====
// ----------------------------------------------------------------------------
// write_batch_record_parser_unit
// Byte-stream parser for write batches: header, put and delete records.
//
// Input stream: one batch byte per beat on req_tdata, req_tlast on the final
// byte. Output stream: one result beat per input beat, in order. tuser gives
// the byte role, tdata the passed byte, record end marker, record kind,
// sequence number and status code, tlast marks the status beat.
// A result beat is registered and shown in the cycle after its input beat
// is accepted. Throughput is one byte per cycle while rsp_tready is high;
// parser state and 64-bit sequence increment update in the accepting cycle.
// The result register frees in the cycle it is taken, so req_tready stays
// high while rsp_tready is high. When the receiver stalls with a result
// held, req_tready drops and the held beat is kept unchanged.
// Reset clears the parser to the header state and empties the result
// register. After each tlast byte the parser returns to the header state.
// ----------------------------------------------------------------------------
module write_batch_record_parser_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // byte_in
   input  logic                               req_tlast,  // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // data_out[7:0], record_end[8], record_is_put[9], record_sequence[73:10],
   // status_code[76:74], zero fill[79:77]
   output logic [wbrp_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic [wbrp_pkg::RspUserWidth-1:0]  rsp_tuser,  // byte_role
   output logic                               rsp_tlast   // status_valid
);
   import wbrp_pkg::*;

   logic       accept;
   result_type result;
   result_type result_ff;
   logic       valid_ff, valid_in;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !rsp_tready);

   wbrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_tdata),
      .last_byte (req_tlast),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = result_ff.role;
   assign rsp_tlast  = result_ff.stat_valid;
   assign rsp_tdata  = {3'b000, result_ff.stat_code, result_ff.rec_seq,
                        result_ff.rec_put, result_ff.rec_end, result_ff.data};

endmodule

// ===== hdl/wbrp_checker.sv =====
// ----------------------------------------------------------------------------
// wbrp_checker
// Port-level checks for the write batch record parser, bound to the top.
// ----------------------------------------------------------------------------
module wbrp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [7:0]                         req_tdata,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [wbrp_pkg::RspDataWidth-1:0]  rsp_tdata,
   input logic [wbrp_pkg::RspUserWidth-1:0]  rsp_tuser,
   input logic                               rsp_tlast
);
   import wbrp_pkg::*;

   // held beat stays put while stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed under stall");

   // each input beat yields a result beat next cycle with its byte and last flag
   a_pass: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid && rsp_tdata[7:0] == $past(req_tdata)
                                   && rsp_tlast == $past(req_tlast))
      else $error("result beat does not follow input beat");

   // ignored bytes never close a record
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ROLE_IGNORED |-> !rsp_tdata[8])
      else $error("ignored byte marked as record end");

   // status code only on the status beat; kind and sequence only on record end
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast || rsp_tdata[76:74] == ST_OK)
                     && (rsp_tdata[8] || (!rsp_tdata[9] && rsp_tdata[73:10] == 64'd0)))
      else $error("status or record fields set outside their beat");

   // no result right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind write_batch_record_parser_unit wbrp_checker u_wbrp_checker (.*);
